[sv/pcdd_pkg.sv]
// Shared types and constants of the prefix-code DPCM image decoder.
package pcdd_pkg;

	// Register indexes of the configuration port.
	localparam logic [3:0] REG_FRAME_WIDTH  = 4'd0;
	localparam logic [3:0] REG_FRAME_HEIGHT = 4'd1;

	localparam int unsigned CFG_INDEX_W = 4;
	localparam int unsigned CFG_DATA_W  = 13;

	// Geometry limits that do not vary with the build.
	localparam int unsigned ROW_W          = 12;
	localparam int unsigned HEIGHT_W       = 13;
	localparam logic [12:0] MIN_GEOMETRY   = 13'd2;
	localparam logic [12:0] MAX_HEIGHT     = 13'd4096;

	// Depth of the token queue between the code decoder and the pixel stage.
	localparam int unsigned TOKQ_DEPTH = 4;

	typedef struct packed {
		logic [7:0] comp_byte;
		logic       frame_start;
	} byte_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic       run_last;
		logic       frame_last;
	} pix_t;

	// How the pixel stage forms its prediction.
	typedef enum logic [1:0] {
		MODE_ABS,
		MODE_UP,
		MODE_LEFT,
		MODE_MEAN
	} mode_t;

	// One decoded code on its way to the pixel stage.
	typedef struct packed {
		mode_t              mode;
		logic signed [8:0]  val;
		logic               par;
		logic               run_last;
		logic               frame_last;
	} token_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_RUN,
		FS_HOLD
	} fs_t;

endpackage

[sv/pcdd_front.sv]
// Code decoder: takes compressed bytes, tracks position and emits one token per code.
module pcdd_front #(
	parameter int unsigned MAX_WIDTH = 1024,
	parameter int unsigned CW        = $clog2(MAX_WIDTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     byte_valid,
	output logic                     byte_stall,
	input  pcdd_pkg::byte_t          byte_data,
	input  logic [CW:0]              eff_w,
	input  logic [12:0]              eff_h,
	output logic                     tok_push,
	output pcdd_pkg::token_t         tok,
	output logic [CW-1:0]            tok_col,
	input  logic                     tok_room
);
	import pcdd_pkg::*;

	// Prefix patterns of the code table.
	localparam logic [7:0] PFX_P4    = 8'h80;
	localparam logic [7:0] PFX_M4    = 8'hA0;
	localparam logic [7:0] PFX_P11   = 8'hD0;
	localparam logic [7:0] PFX_M11   = 8'hF0;
	localparam logic [7:0] PFX_P20   = 8'hC8;
	localparam logic [7:0] PFX_M20   = 8'hC0;
	localparam logic [7:0] PFX_ZERO8 = 8'hC4;
	localparam logic [7:0] MSK_3     = 8'hE0;
	localparam logic [7:0] MSK_4     = 8'hF0;
	localparam logic [7:0] MSK_5     = 8'hF8;
	localparam logic [7:0] MSK_6     = 8'hFC;

	typedef struct packed {
		logic [3:0]        len;
		logic              absval;
		logic signed [8:0] val;
	} cls_t;

	function automatic logic [7:0] peek8(input logic [14:0] b, input logic [3:0] n);
		logic [14:0] t;
		if (n >= 4'd8) begin
			t = b >> (n - 4'd8);
		end else begin
			t = b << (4'd8 - n);
		end
		return t[7:0];
	endfunction

	function automatic cls_t classify(input logic [7:0] b, input logic raw);
		cls_t c;
		c.len    = 4'd8;
		c.absval = 1'b0;
		c.val    = 9'sd0;
		if (raw) begin
			c.absval = 1'b1;
			c.val    = $signed({1'b0, b});
		end else if (!b[7]) begin
			c.len = 4'd1;
		end else if ((b & MSK_3) == PFX_P4) begin
			c.len = 4'd3;
			c.val = 9'sd4;
		end else if ((b & MSK_3) == PFX_M4) begin
			c.len = 4'd3;
			c.val = -9'sd4;
		end else if ((b & MSK_4) == PFX_P11) begin
			c.len = 4'd4;
			c.val = 9'sd11;
		end else if ((b & MSK_4) == PFX_M11) begin
			c.len = 4'd4;
			c.val = -9'sd11;
		end else if ((b & MSK_5) == PFX_P20) begin
			c.len = 4'd5;
			c.val = 9'sd20;
		end else if ((b & MSK_6) == PFX_M20) begin
			c.len = 4'd6;
			c.val = -9'sd20;
		end else if ((b & MSK_6) == PFX_ZERO8) begin
			c.len = 4'd8;
		end else begin
			c.absval = 1'b1;
			c.val    = $signed({1'b0, b[3:0], 4'b0000});
		end
		return c;
	endfunction

	fs_t            state_q, state_d;
	logic [14:0]    buf_q, buf_p, buf_rem;
	logic [3:0]     cnt_q, cnt_p, rem;
	logic [ROW_W-1:0] row_q, row_p, row_n;
	logic [CW-1:0]  col_q, col_p, col_n;
	logic [2:0]     n_q, n_p;
	logic [CW:0]    col_inc;
	logic [12:0]    row_inc;
	cls_t           cls, cls_next;
	logic           raw_here, raw_next, complete, next_complete;
	logic           col_wrap, frame_end, last, want_byte, emit, take;

	// Decode of the code at the head of the buffer, and a look at the one after it.
	always_comb begin
		raw_here      = (row_q < 12'd2) && ({1'b0, col_q} < (CW+1)'(2));
		cls           = classify(peek8(buf_q, cnt_q), raw_here);
		complete      = (cnt_q >= cls.len);
		rem           = cnt_q - cls.len;
		buf_rem       = buf_q & ((15'd1 << rem) - 15'd1);
		col_inc       = {1'b0, col_q} + (CW+1)'(1);
		col_wrap      = (col_inc >= eff_w);
		col_n         = col_wrap ? '0 : col_inc[CW-1:0];
		row_inc       = {1'b0, row_q} + 13'd1;
		row_n         = col_wrap ? row_inc[ROW_W-1:0] : row_q;
		frame_end     = col_wrap && (row_inc >= eff_h);
		raw_next      = (row_n < 12'd2) && ({1'b0, col_n} < (CW+1)'(2));
		cls_next      = classify(peek8(buf_rem, rem), raw_next);
		next_complete = (rem >= cls_next.len);
		last          = !next_complete || (n_q == 3'd7) || frame_end;
	end

	// Handshake and token outputs.
	always_comb begin
		want_byte  = (state_q != FS_RUN) || !complete;
		emit       = (state_q == FS_RUN) && complete && tok_room;
		byte_stall = !(want_byte || (emit && last));
		take       = byte_valid && !byte_stall;

		tok_push       = emit;
		tok.val        = cls.val;
		tok.par        = row_q[0];
		tok.run_last   = last;
		tok.frame_last = frame_end;
		tok_col        = col_q;
		if (cls.absval) begin
			tok.mode = MODE_ABS;
		end else if ({1'b0, col_q} < (CW+1)'(2)) begin
			tok.mode = MODE_UP;
		end else if (row_q < 12'd2) begin
			tok.mode = MODE_LEFT;
		end else begin
			tok.mode = MODE_MEAN;
		end

		buf_p = buf_q;
		cnt_p = cnt_q;
		row_p = row_q;
		col_p = col_q;
		n_p   = n_q;
		if (emit) begin
			buf_p = frame_end ? '0 : buf_rem;
			cnt_p = frame_end ? '0 : rem;
			row_p = row_n;
			col_p = col_n;
			n_p   = n_q + 3'd1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_IDLE: begin
				if (take && byte_data.frame_start) begin
					state_d = FS_RUN;
				end
			end
			FS_RUN: begin
				if (emit && last) begin
					state_d = frame_end ? FS_IDLE : FS_HOLD;
				end
				if (take && (byte_data.frame_start || !(emit && frame_end))) begin
					state_d = FS_RUN;
				end
			end
			FS_HOLD: begin
				if (take) begin
					state_d = FS_RUN;
				end
			end
			default: begin
				state_d = FS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			buf_q   <= '0;
			cnt_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			if (take && byte_data.frame_start) begin
				buf_q <= {7'b0, byte_data.comp_byte};
				cnt_q <= 4'd8;
				row_q <= '0;
				col_q <= '0;
				n_q   <= '0;
			end else if (take && (state_d == FS_RUN)) begin
				buf_q <= {buf_p[6:0], byte_data.comp_byte};
				cnt_q <= cnt_p + 4'd8;
				row_q <= row_p;
				col_q <= col_p;
				n_q   <= '0;
			end else begin
				buf_q <= buf_p;
				cnt_q <= cnt_p;
				row_q <= row_p;
				col_q <= col_p;
				n_q   <= n_p;
			end
		end
	end

endmodule

[sv/pcdd_queue.sv]
// Short token queue between the code decoder and the pixel stage.
module pcdd_queue #(
	parameter int unsigned CW = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pcdd_pkg::token_t  push_tok,
	input  logic [CW-1:0]     push_col,
	output logic              room,
	input  logic              pop,
	output pcdd_pkg::token_t  head_tok,
	output logic [CW-1:0]     head_col,
	output logic              nonempty
);
	import pcdd_pkg::*;

	localparam int unsigned PW = $clog2(TOKQ_DEPTH);

	token_t          tok_mem [TOKQ_DEPTH];
	logic [CW-1:0]   col_mem [TOKQ_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PW:0]     count_q;

	assign room     = (count_q != (PW+1)'(TOKQ_DEPTH));
	assign nonempty = (count_q != '0);
	assign head_tok = tok_mem[rd_ptr_q];
	assign head_col = col_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			tok_mem[wr_ptr_q] <= push_tok;
			col_mem[wr_ptr_q] <= push_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule

[sv/pcdd_back.sv]
// Pixel stage: reads the line store, forms the prediction, clamps and presents pixels.
module pcdd_back #(
	parameter int unsigned MAX_WIDTH = 1024,
	parameter int unsigned CW        = $clog2(MAX_WIDTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_nonempty,
	input  pcdd_pkg::token_t  q_tok,
	input  logic [CW-1:0]     q_col,
	output logic              q_pop,
	output logic              pix_valid,
	input  logic              pix_stall,
	output pcdd_pkg::pix_t    pix_data
);
	import pcdd_pkg::*;

	localparam int unsigned DEPTH = 2 * MAX_WIDTH;
	localparam int unsigned AW    = $clog2(DEPTH);

	// Two rows of pixels, one per row parity.
	logic [7:0]         line_mem [DEPTH];
	logic [7:0]         up_s1;
	logic [AW-1:0]      rd_addr, addr_s1;
	token_t             tok_s1;
	logic               valid_s1, adv_s1;
	logic               out_valid_q;
	pix_t               out_q;
	logic [7:0]         hist1_q, hist2_q;
	logic [8:0]         mean_sum;
	logic [7:0]         pred;
	logic signed [10:0] sum;
	logic [7:0]         pix_new;

	assign rd_addr = q_tok.par ? (AW'(MAX_WIDTH) + AW'(q_col)) : AW'(q_col);
	assign adv_s1  = valid_s1 && (!out_valid_q || !pix_stall);
	assign q_pop   = q_nonempty && (!valid_s1 || adv_s1);

	always_comb begin
		mean_sum = {1'b0, up_s1} + {1'b0, hist2_q};
		case (tok_s1.mode)
			MODE_UP:   pred = up_s1;
			MODE_LEFT: pred = hist2_q;
			MODE_MEAN: pred = mean_sum[8:1];
			default:   pred = 8'd0;
		endcase
		sum = 11'(tok_s1.val) + $signed({3'b000, pred});
		if (sum < 11'sd0) begin
			pix_new = 8'd0;
		end else if (sum > 11'sd255) begin
			pix_new = 8'd255;
		end else begin
			pix_new = sum[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			up_s1   <= line_mem[rd_addr];
			addr_s1 <= rd_addr;
			tok_s1  <= q_tok;
		end
		if (adv_s1) begin
			line_mem[addr_s1] <= pix_new;
			hist2_q           <= hist1_q;
			hist1_q           <= pix_new;
			out_q.pixel       <= pix_new;
			out_q.run_last    <= tok_s1.run_last;
			out_q.frame_last  <= tok_s1.frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (!pix_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pix_valid = out_valid_q;
	assign pix_data  = out_q;

endmodule

[sv/prefix_code_dpcm_image_decoder.sv]
// Prefix-code DPCM image decoder. Compressed bytes enter on the byte channel, most
// significant bit first, and 8-bit pixels leave on the pixel channel in raster order, one
// pixel per cycle at best. The code decoder handles one code per cycle while the token
// queue has room, and one byte completes at most eight codes. A four-entry token queue
// separates the code decoder from the pixel
// stage, which reads the line store (2*MAX_WIDTH bytes, one read and one write per cycle)
// and holds its result in an output register. The line store is not cleared at reset.
// Configuration writes are always taken; width is clamped to 2..MAX_WIDTH and height to
// 2..4096, and both should be written while the block is idle.
module prefix_code_dpcm_image_decoder #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                byte_valid,
	output logic                                byte_stall,
	input  pcdd_pkg::byte_t                     byte_data,
	output logic                                pix_valid,
	input  logic                                pix_stall,
	output pcdd_pkg::pix_t                      pix_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pcdd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pcdd_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pcdd_pkg::*;

	localparam int unsigned CW = $clog2(MAX_WIDTH);

	logic [10:0]  frame_width_q;
	logic [12:0]  frame_height_q;
	logic [12:0]  fw_ext, w_clamp, h_clamp;
	logic [CW:0]  eff_w;
	token_t       f_tok, q_tok;
	logic [CW-1:0] f_col, q_col;
	logic         f_push, q_room, q_pop, q_nonempty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 11'd640;
			frame_height_q <= 13'd480;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[10:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_comb begin
		fw_ext = {2'b00, frame_width_q};
		if (fw_ext < MIN_GEOMETRY) begin
			w_clamp = MIN_GEOMETRY;
		end else if (fw_ext > 13'(MAX_WIDTH)) begin
			w_clamp = 13'(MAX_WIDTH);
		end else begin
			w_clamp = fw_ext;
		end
		eff_w = w_clamp[CW:0];
		if (frame_height_q < MIN_GEOMETRY) begin
			h_clamp = MIN_GEOMETRY;
		end else if (frame_height_q > MAX_HEIGHT) begin
			h_clamp = MAX_HEIGHT;
		end else begin
			h_clamp = frame_height_q;
		end
	end

	pcdd_front #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.eff_w      (eff_w),
		.eff_h      (h_clamp),
		.tok_push   (f_push),
		.tok        (f_tok),
		.tok_col    (f_col),
		.tok_room   (q_room)
	);

	pcdd_queue #(.CW(CW)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.push_tok (f_tok),
		.push_col (f_col),
		.room     (q_room),
		.pop      (q_pop),
		.head_tok (q_tok),
		.head_col (q_col),
		.nonempty (q_nonempty)
	);

	pcdd_back #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_tok      (q_tok),
		.q_col      (q_col),
		.q_pop      (q_pop),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix_data   (pix_data)
	);

endmodule

[sv/pcdd_checker.sv]
// Port-level checks of the decoder, bound to its top level.
module pcdd_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                byte_valid,
	input  logic                                byte_stall,
	input  pcdd_pkg::byte_t                     byte_data,
	input  logic                                pix_valid,
	input  logic                                pix_stall,
	input  pcdd_pkg::pix_t                      pix_data,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready
);
	import pcdd_pkg::*;

	// The final pixel of a frame also closes the run of its byte.
	a_frame_last_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_data.frame_last |-> pix_data.run_last)
		else $error("frame_last without run_last");

	// A stalled pixel request keeps its payload.
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid && $stable(pix_data))
		else $error("stalled pixel changed or dropped");

	// Configuration writes are never held off.
	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

	// A stalled byte request stays on the port unchanged.
	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(byte_data))
		else $error("stalled byte changed or dropped");

endmodule

bind prefix_code_dpcm_image_decoder pcdd_checker u_pcdd_checker (.*);
